// File: sv/ast_pkg.sv
// Shared constants and types for the assembly source tokenizer.
package ast_pkg;

   localparam int CODE_BITS        = 8;
   localparam int CHAR_OFFSET_BITS = 32;
   localparam int CHAR_WIDTH_BITS  = 3;
   localparam int KIND_BITS        = 4;

   typedef logic [KIND_BITS-1:0] kind_type;
   typedef logic [CODE_BITS-1:0] char_type;

   // token kinds as delivered
   localparam kind_type KIND_SPACE   = 4'd0;
   localparam kind_type KIND_LINE    = 4'd1;
   localparam kind_type KIND_IDENT   = 4'd2;
   localparam kind_type KIND_KEYWORD = 4'd3;
   localparam kind_type KIND_COMMENT = 4'd4;
   localparam kind_type KIND_LITERAL = 4'd5;
   localparam kind_type KIND_SYMBOL  = 4'd6;
   localparam kind_type KIND_EOF     = 4'd7;
   localparam kind_type KIND_UNKNOWN = 4'd8;
   // open-token codes: DEC, HEX and BIN while a literal is being scanned, NONE when no token is open
   localparam kind_type OPEN_DEC     = 4'd9;
   localparam kind_type OPEN_HEX     = 4'd10;
   localparam kind_type OPEN_BIN     = 4'd11;
   localparam kind_type OPEN_NONE    = 4'd15;

   // characters
   localparam char_type CH_TAB    = 8'h09;
   localparam char_type CH_LF     = 8'h0A;
   localparam char_type CH_CR     = 8'h0D;
   localparam char_type CH_SPACE  = 8'h20;
   localparam char_type CH_HASH   = 8'h23;
   localparam char_type CH_DOLLAR = 8'h24;
   localparam char_type CH_PCENT  = 8'h25;
   localparam char_type CH_LPAREN = 8'h28;
   localparam char_type CH_RPAREN = 8'h29;
   localparam char_type CH_STAR   = 8'h2A;
   localparam char_type CH_PLUS   = 8'h2B;
   localparam char_type CH_COMMA  = 8'h2C;
   localparam char_type CH_MINUS  = 8'h2D;
   localparam char_type CH_DOT    = 8'h2E;
   localparam char_type CH_ZERO   = 8'h30;
   localparam char_type CH_ONE    = 8'h31;
   localparam char_type CH_NINE   = 8'h39;
   localparam char_type CH_COLON  = 8'h3A;
   localparam char_type CH_SEMI   = 8'h3B;
   localparam char_type CH_UC_A   = 8'h41;
   localparam char_type CH_UC_F   = 8'h46;
   localparam char_type CH_UC_X   = 8'h58;
   localparam char_type CH_UC_Y   = 8'h59;
   localparam char_type CH_UC_Z   = 8'h5A;
   localparam char_type CH_UNDER  = 8'h5F;
   localparam char_type CH_LC_A   = 8'h61;
   localparam char_type CH_LC_F   = 8'h66;
   localparam char_type CH_LC_Z   = 8'h7A;

endpackage

// File: sv/ast_req_if.sv
// Character channel: one source character per transaction.
interface ast_req_if;
   import ast_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [CODE_BITS-1:0]        char_code;
   logic [CHAR_OFFSET_BITS-1:0] char_offset;
   logic [CHAR_WIDTH_BITS-1:0]  char_width;
   logic                        at_end;

   modport source (output valid, char_code, char_offset, char_width, at_end, input ready);
   modport sink   (input valid, char_code, char_offset, char_width, at_end, output ready);
endinterface

// File: sv/ast_rsp_if.sv
// Token channel: one token per transaction.
interface ast_rsp_if #(
   parameter int OFFSET_BITS = 32,
   parameter int LENGTH_BITS = 16
);
   import ast_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [KIND_BITS-1:0]   token_kind;
   logic [OFFSET_BITS-1:0] token_start;
   logic [LENGTH_BITS-1:0] token_length;
   logic                   space_before;
   logic                   line_start;
   logic                   trivia;
   logic                   last_of_run;

   modport source (output valid, token_kind, token_start, token_length, space_before,
                   line_start, trivia, last_of_run, input ready);
   modport sink   (input valid, token_kind, token_start, token_length, space_before,
                   line_start, trivia, last_of_run, output ready);
endinterface

// File: sv/assembly_source_tokenizer_top.sv
// Assembly source tokenizer: characters in, tokens out.
//
// req_if carries one source character per transaction (code, byte offset,
// encoded width, end flag). rsp_if carries one token per transaction; a
// character closes zero, one or two tokens, last_of_run marks the final one.
// A transaction moves on a rising clock edge with valid and ready both high.
//
// A character taken on req_if is held in the input register and decoded from
// it; its tokens are written into a four-entry token queue once that queue has
// room for two, and the queue's head is offered on rsp_if from its registers.
// Throughput: one character per cycle. The input register moves on whenever
// the token queue has room for two tokens, so rsp_if sets the rate only when
// tokens pile up (characters that close two tokens, or a stalled receiver).
// When the receiver stalls, the queue fills and req_if.ready drops; nothing is
// lost or repeated. req_if.ready depends on registered state only.
//
// Reset (synchronous, active high) empties the input register and the queue,
// leaves no token open, and marks the next token as first on its line.
module assembly_source_tokenizer_top #(
   parameter int OFFSET_BITS = 32,
   parameter int LENGTH_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   ast_req_if.sink   req_if,
   ast_rsp_if.source rsp_if
);
   import ast_pkg::*;

   localparam int FIFO_DEPTH = 4;
   localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
   localparam int CNT_BITS   = PTR_BITS + 1;
   localparam int LEN_EXT    = LENGTH_BITS + 1;

   typedef struct packed {
      kind_type               kind;
      logic [OFFSET_BITS-1:0] start;
      logic [LENGTH_BITS-1:0] length;
      logic                   space_before;
      logic                   line_start;
      logic                   trivia;
      logic                   last_of_run;
   } tok_entry_type;

   // saturating length accumulate
   function automatic logic [LENGTH_BITS-1:0] sat_add(input logic [LENGTH_BITS-1:0] a,
                                                      input logic [CHAR_WIDTH_BITS-1:0] b);
      logic [LENGTH_BITS:0] s;
      s = {1'b0, a} + LEN_EXT'(b);
      return s[LENGTH_BITS] ? '1 : s[LENGTH_BITS-1:0];
   endfunction

   // ---------------- input register ----------------
   logic                        in_valid_ff, in_valid_in;
   logic [CODE_BITS-1:0]        in_code_ff;
   logic [CHAR_OFFSET_BITS-1:0] in_offset_ff;
   logic [CHAR_WIDTH_BITS-1:0]  in_width_ff;
   logic                        in_end_ff;

   // ---------------- lexer state ----------------
   kind_type               open_kind_ff, open_kind_in;
   logic                   cr_prefix_ff, cr_prefix_in;
   logic [OFFSET_BITS-1:0] open_start_ff, open_start_in;
   logic [LENGTH_BITS-1:0] open_length_ff, open_length_in;
   logic                   keyword_ff, keyword_in;
   logic                   after_space_ff, after_space_in;
   logic                   after_line_ff, after_line_in;

   // ---------------- token queue ----------------
   tok_entry_type         tok_mem_ff [FIFO_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in, wr_ptr_nx;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [CNT_BITS-1:0]   n_wr;

   logic room, adv, take, pop;

   assign room = (count_ff <= CNT_BITS'(FIFO_DEPTH - 2));
   assign adv  = in_valid_ff && room;
   assign req_if.ready = !in_valid_ff || room;
   assign take = req_if.valid && req_if.ready;
   assign pop  = rsp_if.valid && rsp_if.ready;

   always_comb begin
      if (take) begin
         in_valid_in = 1'b1;
      end else if (adv) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // ---------------- character classes ----------------
   char_type c;
   logic is_blank, is_digit, is_alpha, is_xdigit, is_sym_char, is_cr, is_lf;
   logic is_nzdigit, is_bin, is_xy;

   assign c = in_code_ff;

   always_comb begin
      is_blank    = c inside {CH_SPACE, CH_TAB};
      is_digit    = c inside {[CH_ZERO:CH_NINE]};
      is_nzdigit  = c inside {[CH_ONE:CH_NINE]};
      is_bin      = c inside {CH_ZERO, CH_ONE};
      is_alpha    = c inside {[CH_LC_A:CH_LC_Z], [CH_UC_A:CH_UC_Z]};
      is_xdigit   = c inside {[CH_ZERO:CH_NINE], [CH_LC_A:CH_LC_F], [CH_UC_A:CH_UC_F]};
      is_sym_char = c inside {CH_DOT, CH_COLON, CH_LPAREN, CH_RPAREN, CH_COMMA,
                              CH_PLUS, CH_MINUS, CH_HASH, CH_STAR};
      is_xy       = c inside {CH_UC_X, CH_UC_Y};
      is_cr       = (c == CH_CR);
      is_lf       = (c == CH_LF);
   end

   // does the character extend the open token
   logic cont;
   always_comb begin
      case (open_kind_ff)
         KIND_SPACE:   cont = is_blank;
         KIND_IDENT:   cont = is_alpha || is_digit || (c == CH_UNDER);
         KIND_COMMENT: cont = !is_cr && !is_lf;
         OPEN_DEC:     cont = is_digit;
         OPEN_HEX:     cont = is_xdigit;
         OPEN_BIN:     cont = is_bin;
         KIND_UNKNOWN: cont = !is_blank && !is_lf;
         default:      cont = 1'b0;
      endcase
   end

   // kind reported when the open token closes
   kind_type close_kind;
   always_comb begin
      case (open_kind_ff)
         OPEN_DEC, OPEN_HEX, OPEN_BIN: close_kind = KIND_LITERAL;
         KIND_IDENT:                   close_kind = keyword_ff ? KIND_KEYWORD : KIND_IDENT;
         default:                      close_kind = open_kind_ff;
      endcase
   end

   // ---------------- token decode ----------------
   tok_entry_type          t0, t1;
   logic                   t0_valid, t1_valid;
   logic                   open_active, keep_cr;
   logic                   sb1, ls1;
   logic [OFFSET_BITS-1:0] new_start;
   logic [LENGTH_BITS-1:0] new_len;

   assign open_active = (open_kind_ff != OPEN_NONE);

   always_comb begin
      open_kind_in   = open_kind_ff;
      cr_prefix_in   = cr_prefix_ff;
      open_start_in  = open_start_ff;
      open_length_in = open_length_ff;
      keyword_in     = keyword_ff;
      after_space_in = after_space_ff;
      after_line_in  = after_line_ff;
      t0_valid       = 1'b0;
      t1_valid       = 1'b0;
      keep_cr        = cr_prefix_ff && !is_blank;
      sb1            = open_active ? (close_kind == KIND_SPACE) : after_space_ff;
      ls1            = open_active ? 1'b0 : after_line_ff;
      new_start      = keep_cr ? open_start_ff : OFFSET_BITS'(in_offset_ff);
      new_len        = sat_add(keep_cr ? open_length_ff : '0, in_width_ff);

      // closing token of the open run
      t0.kind         = close_kind;
      t0.start        = open_start_ff;
      t0.length       = open_length_ff;
      t0.space_before = after_space_ff;
      t0.line_start   = after_line_ff;
      t0.trivia       = (close_kind == KIND_SPACE) || (close_kind == KIND_COMMENT);
      t0.last_of_run  = 1'b0;

      t1.kind         = KIND_EOF;
      t1.start        = '0;
      t1.length       = '0;
      t1.space_before = 1'b0;
      t1.line_start   = 1'b0;
      t1.trivia       = 1'b0;
      t1.last_of_run  = 1'b1;

      if (in_end_ff) begin
         // flush open token, drop a pending CR, then end of file
         t0_valid       = open_active;
         t1_valid       = 1'b1;
         open_kind_in   = OPEN_NONE;
         cr_prefix_in   = 1'b0;
         keyword_in     = 1'b0;
         after_space_in = 1'b0;
         after_line_in  = 1'b0;
      end else if (open_active && cont) begin
         open_length_in = sat_add(open_length_ff, in_width_ff);
         keyword_in     = 1'b0;
      end else begin
         t0_valid       = open_active;
         open_start_in  = new_start;
         open_length_in = new_len;
         open_kind_in   = OPEN_NONE;
         cr_prefix_in   = 1'b0;
         keyword_in     = 1'b0;
         after_space_in = sb1;
         after_line_in  = ls1;
         t1.space_before = sb1;
         t1.line_start   = ls1;
         if (cr_prefix_ff && is_blank) begin
            // lone CR before a blank stands as an unknown token
            t1_valid       = 1'b1;
            t1.kind        = KIND_UNKNOWN;
            t1.start       = open_start_ff;
            t1.length      = open_length_ff;
            after_space_in = 1'b0;
            after_line_in  = 1'b0;
         end
         if (is_blank) begin
            open_kind_in = KIND_SPACE;
         end else if (!cr_prefix_ff && is_cr) begin
            cr_prefix_in = 1'b1;
         end else if (is_lf) begin
            t1_valid       = 1'b1;
            t1.kind        = KIND_LINE;
            t1.start       = new_start;
            t1.length      = new_len;
            after_space_in = 1'b0;
            after_line_in  = 1'b1;
         end else if (is_alpha || (c == CH_UNDER)) begin
            open_kind_in = KIND_IDENT;
            keyword_in   = !cr_prefix_ff && is_xy;
         end else if (c == CH_SEMI) begin
            open_kind_in = KIND_COMMENT;
         end else if (is_nzdigit) begin
            open_kind_in = OPEN_DEC;
         end else if (c == CH_DOLLAR) begin
            open_kind_in = OPEN_HEX;
         end else if (c == CH_PCENT) begin
            open_kind_in = OPEN_BIN;
         end else if (is_sym_char) begin
            t1_valid       = 1'b1;
            t1.kind        = KIND_SYMBOL;
            t1.start       = new_start;
            t1.length      = new_len;
            after_space_in = 1'b0;
            after_line_in  = 1'b0;
         end else begin
            open_kind_in = KIND_UNKNOWN;
         end
      end

      t0.last_of_run = !t1_valid;
   end

   // ---------------- queue bookkeeping ----------------
   tok_entry_type first_tok;

   assign first_tok = t0_valid ? t0 : t1;
   assign n_wr      = adv ? (CNT_BITS'(t0_valid) + CNT_BITS'(t1_valid)) : '0;
   assign wr_ptr_nx = wr_ptr_ff + PTR_BITS'(1);
   assign wr_ptr_in = wr_ptr_ff + n_wr[PTR_BITS-1:0];
   assign rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
   assign count_in  = count_ff + n_wr - CNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         count_ff       <= '0;
         open_kind_ff   <= OPEN_NONE;
         cr_prefix_ff   <= 1'b0;
         open_start_ff  <= '0;
         open_length_ff <= '0;
         keyword_ff     <= 1'b0;
         after_space_ff <= 1'b0;
         after_line_ff  <= 1'b1;
      end else begin
         in_valid_ff <= in_valid_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
         if (adv) begin
            open_kind_ff   <= open_kind_in;
            cr_prefix_ff   <= cr_prefix_in;
            open_start_ff  <= open_start_in;
            open_length_ff <= open_length_in;
            keyword_ff     <= keyword_in;
            after_space_ff <= after_space_in;
            after_line_ff  <= after_line_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (take) begin
         in_code_ff   <= req_if.char_code;
         in_offset_ff <= req_if.char_offset;
         in_width_ff  <= req_if.char_width;
         in_end_ff    <= req_if.at_end;
      end
      if (adv && (t0_valid || t1_valid)) begin
         tok_mem_ff[wr_ptr_ff] <= first_tok;
      end
      if (adv && t0_valid && t1_valid) begin
         tok_mem_ff[wr_ptr_nx] <= t1;
      end
   end

   // ---------------- token output ----------------
   tok_entry_type head;

   assign head                = tok_mem_ff[rd_ptr_ff];
   assign rsp_if.valid        = (count_ff != '0);
   assign rsp_if.token_kind   = head.kind;
   assign rsp_if.token_start  = head.start;
   assign rsp_if.token_length = head.length;
   assign rsp_if.space_before = head.space_before;
   assign rsp_if.line_start   = head.line_start;
   assign rsp_if.trivia       = head.trivia;
   assign rsp_if.last_of_run  = head.last_of_run;

endmodule

// File: sim/assembly_source_tokenizer_top_tb.sv
// Self-checking testbench for the assembly source tokenizer: directed table, then random source.
module assembly_source_tokenizer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ast_pkg::*;

   localparam int OFF_BITS     = 32;
   localparam int LEN_BITS     = 16;
   // Quiet cycles (no transaction on either side) before the run is declared hung.
   // The longest legal quiet stretch is a receiver hold-off of HOLD_CYCLES plus a
   // short sender gap, so this is several times that.
   localparam int HOLD_CYCLES  = 400;
   localparam int QUIET_LIMIT  = 2000;
   // Input register plus token queue: the DRAIN_CYCLES wait covers anything in flight.
   localparam int DRAIN_CYCLES = 8;
   // Random characters after the directed table, about 1200 in all.
   localparam int RANDOM_ITEMS = 1170;

   localparam char_type CH_HIGH = 8'hFF;

   typedef struct packed {
      kind_type              kind;
      logic [OFF_BITS-1:0]   start;
      logic [LEN_BITS-1:0]   length;
      logic                  space_before;
      logic                  line_start;
      logic                  trivia;
      logic                  last_of_run;
   } tok_rec_type;

   typedef struct packed {
      char_type                    code;
      logic [CHAR_OFFSET_BITS-1:0] offset;
      logic [CHAR_WIDTH_BITS-1:0]  width;
      logic                        at_end;
      logic                        typed;   // want holds the token to expect
      tok_rec_type                 want;
   } char_item_type;

   typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_type;

   localparam tok_rec_type NO_TOKEN  = '0;
   localparam tok_rec_type EOF_TOKEN = '{KIND_EOF, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1};

   // Directed table. Only end-of-file rows carry a typed token; every other row
   // is checked against the predictor.
   localparam int NUM_DIRECTED = 29;
   localparam char_item_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      '{CH_HIGH,   32'd0,  3'd1, 1'b1, 1'b1, EOF_TOKEN},  // end straight after reset
      '{CH_HIGH,   32'd0,  3'd1, 1'b1, 1'b1, EOF_TOKEN},  // end again
      '{CH_UC_X,   32'd0,  3'd1, 1'b0, 1'b0, NO_TOKEN},   // lone X -> keyword
      '{CH_SPACE,  32'd1,  3'd1, 1'b0, 1'b0, NO_TOKEN},
      '{CH_TAB,    32'd2,  3'd4, 1'b0, 1'b0, NO_TOKEN},
      '{CH_UC_Y,   32'd6,  3'd1, 1'b0, 1'b0, NO_TOKEN},   // Y_ is a plain identifier
      '{CH_UNDER,  32'd7,  3'd1, 1'b0, 1'b0, NO_TOKEN},
      '{CH_SEMI,   32'd8,  3'd1, 1'b0, 1'b0, NO_TOKEN},
      '{CH_HIGH,   32'd9,  3'd4, 1'b0, 1'b0, NO_TOKEN},   // top-bit code inside comment
      '{CH_CR,     32'd13, 3'd1, 1'b0, 1'b0, NO_TOKEN},
      '{CH_LF,     32'd14, 3'd1, 1'b0, 1'b0, NO_TOKEN},   // CR LF line end
      '{CH_CR,     32'd15, 3'd1, 1'b0, 1'b0, NO_TOKEN},
      '{CH_SPACE,  32'd16, 3'd1, 1'b0, 1'b0, NO_TOKEN},   // CR then blank -> unknown
      '{CH_CR,     32'd17, 3'd1, 1'b0, 1'b0, NO_TOKEN},
      '{CH_UC_X,   32'd18, 3'd1, 1'b0, 1'b0, NO_TOKEN},   // CR-led X is no keyword
      '{CH_NINE,   32'd19, 3'd1, 1'b0, 1'b0, NO_TOKEN},
      '{CH_DOLLAR, 32'd20, 3'd1, 1'b0, 1'b0, NO_TOKEN},
      '{CH_LC_F,   32'd21, 3'd1, 1'b0, 1'b0, NO_TOKEN},
      '{CH_PCENT,  32'd22, 3'd1, 1'b0, 1'b0, NO_TOKEN},
      '{CH_ONE,    32'd23, 3'd1, 1'b0, 1'b0, NO_TOKEN},
      '{CH_ZERO,   32'd24, 3'd7, 1'b0, 1'b0, NO_TOKEN},   // width beyond four
      '{CH_NINE,   32'd31, 3'd1, 1'b0, 1'b0, NO_TOKEN},
      '{CH_DOT,    32'd32, 3'd1, 1'b0, 1'b0, NO_TOKEN},   // literal and symbol together
      '{CH_ZERO,   32'd33, 3'd1, 1'b0, 1'b0, NO_TOKEN},   // leading zero -> unknown
      '{CH_LF,     32'd34, 3'd1, 1'b0, 1'b0, NO_TOKEN},
      '{CH_CR,     32'd35, 3'd1, 1'b0, 1'b0, NO_TOKEN},
      '{CH_HIGH,   32'd0,  3'd1, 1'b1, 1'b1, EOF_TOKEN},  // lone CR dropped at end
      '{CH_LC_Z,   32'hFFFF_FFFF, 3'd0, 1'b0, 1'b0, NO_TOKEN},
      '{CH_HIGH,   32'd0,  3'd1, 1'b1, 1'b0, NO_TOKEN}    // open identifier, then end
   };

   logic clock = 1'b0;
   logic reset;

   ast_req_if req_if();
   ast_rsp_if #(.OFFSET_BITS(OFF_BITS), .LENGTH_BITS(LEN_BITS)) rsp_if();

   assembly_source_tokenizer_top #(
      .OFFSET_BITS(OFF_BITS),
      .LENGTH_BITS(LEN_BITS)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Lexer predictor: its own copy of the open token and line flags.
   // ------------------------------------------------------------------
   kind_type            lex_open;
   logic                lex_cr;          // a CR is waiting to lead the next token
   logic [OFF_BITS-1:0] lex_start;
   logic [LEN_BITS-1:0] lex_len;
   logic                lex_kw;          // open identifier is still a lone X or Y
   logic                lex_after_space;
   logic                lex_after_line;

   tok_rec_type run_tokens[$];   // tokens caused by the character just taken
   tok_rec_type token_q[$];      // tokens still owed by the block

   function automatic bit is_blank(char_type c);
      return c == CH_SPACE || c == CH_TAB;
   endfunction

   function automatic bit is_digit(char_type c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic bit is_alpha(char_type c);
      return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z);
   endfunction

   // Does character c extend the token that is open?
   function automatic bit extends_open(char_type c);
      case (lex_open)
         KIND_SPACE:   return is_blank(c);
         KIND_IDENT:   return is_alpha(c) || is_digit(c) || c == CH_UNDER;
         KIND_COMMENT: return c != CH_CR && c != CH_LF;
         OPEN_DEC:     return is_digit(c);
         OPEN_HEX:     return is_digit(c) || (c >= CH_LC_A && c <= CH_LC_F) ||
                              (c >= CH_UC_A && c <= CH_UC_F);
         OPEN_BIN:     return c == CH_ZERO || c == CH_ONE;
         KIND_UNKNOWN: return !is_blank(c) && c != CH_LF;
         default:      return 1'b0;
      endcase
   endfunction

   task automatic grow(input logic [CHAR_WIDTH_BITS-1:0] w);
      logic [LEN_BITS:0] sum;
      sum = {1'b0, lex_len} + (LEN_BITS+1)'(w);
      lex_len = sum[LEN_BITS] ? '1 : sum[LEN_BITS-1:0];
   endtask

   task automatic add_token(input kind_type k, input logic [OFF_BITS-1:0] s,
                            input logic [LEN_BITS-1:0] l, input logic sb,
                            input logic ls, input logic tr);
      tok_rec_type t;
      t.kind         = k;
      t.start        = s;
      t.length       = l;
      t.space_before = sb;
      t.line_start   = ls;
      t.trivia       = tr;
      t.last_of_run  = 1'b0;
      run_tokens.insert(run_tokens.size(), t);
   endtask

   task automatic emit_open(input kind_type k, input logic tr);
      add_token(k, lex_start, lex_len, lex_after_space, lex_after_line, tr);
      lex_after_space = (k == KIND_SPACE);
      lex_after_line  = (k == KIND_LINE);
      lex_open        = OPEN_NONE;
      lex_cr          = 1'b0;
      lex_kw          = 1'b0;
   endtask

   task automatic close_open();
      kind_type k;
      k = lex_open;
      if (k == OPEN_DEC || k == OPEN_HEX || k == OPEN_BIN) k = KIND_LITERAL;
      else if (k == KIND_IDENT && lex_kw) k = KIND_KEYWORD;
      emit_open(k, k == KIND_SPACE || k == KIND_COMMENT);
   endtask

   task automatic lexer_reset();
      lex_open        = OPEN_NONE;
      lex_cr          = 1'b0;
      lex_start       = '0;
      lex_len         = '0;
      lex_kw          = 1'b0;
      lex_after_space = 1'b0;
      lex_after_line  = 1'b1;
   endtask

   // Works out the tokens one accepted character causes, into run_tokens.
   task automatic lex_char(input char_item_type it);
      char_type    c;
      tok_rec_type t;
      c = it.code;
      run_tokens.delete();
      if (it.at_end) begin
         if (lex_open != OPEN_NONE) close_open();
         lex_cr   = 1'b0;
         lex_open = OPEN_NONE;
         lex_kw   = 1'b0;
         add_token(KIND_EOF, '0, '0, 1'b0, 1'b0, 1'b0);
         lex_after_space = 1'b0;
         lex_after_line  = 1'b0;
      end else if (lex_open != OPEN_NONE && extends_open(c)) begin
         grow(it.width);
         if (lex_open == KIND_IDENT) lex_kw = 1'b0;
      end else begin
         if (lex_open != OPEN_NONE) close_open();
         // pending CR before a blank stands on its own
         if (lex_cr && is_blank(c)) emit_open(KIND_UNKNOWN, 1'b0);
         if (!lex_cr) begin
            lex_start = OFF_BITS'(it.offset);
            lex_len   = '0;
         end
         grow(it.width);
         if (!lex_cr && is_blank(c)) lex_open = KIND_SPACE;
         else if (!lex_cr && c == CH_CR) lex_cr = 1'b1;
         else if (c == CH_LF) emit_open(KIND_LINE, 1'b0);
         else if (is_alpha(c) || c == CH_UNDER) begin
            lex_kw   = !lex_cr && (c == CH_UC_X || c == CH_UC_Y);
            lex_open = KIND_IDENT;
         end
         else if (c == CH_SEMI) lex_open = KIND_COMMENT;
         else if (c >= CH_ONE && c <= CH_NINE) lex_open = OPEN_DEC;
         else if (c == CH_DOLLAR) lex_open = OPEN_HEX;
         else if (c == CH_PCENT) lex_open = OPEN_BIN;
         else if (c inside {CH_DOT, CH_COLON, CH_LPAREN, CH_RPAREN, CH_COMMA,
                            CH_PLUS, CH_MINUS, CH_HASH, CH_STAR})
            emit_open(KIND_SYMBOL, 1'b0);
         else lex_open = KIND_UNKNOWN;
         if (lex_open != OPEN_NONE) lex_cr = 1'b0;
      end
      if (run_tokens.size() > 0) begin
         t = run_tokens[run_tokens.size()-1];
         t.last_of_run = 1'b1;
         run_tokens[run_tokens.size()-1] = t;
      end
   endtask

   // ------------------------------------------------------------------
   // Source text generator: fills src_q with characters.
   // ------------------------------------------------------------------
   char_item_type               src_q[$];
   logic [CHAR_OFFSET_BITS-1:0] next_offset;

   task automatic add_w(input char_type c, input logic [CHAR_WIDTH_BITS-1:0] w,
                        input logic fin);
      char_item_type it;
      // now and then jump to a fresh offset so every offset bit moves
      if (!fin && $urandom_range(0, 99) < 3) next_offset = $urandom;
      it.code   = c;
      it.offset = fin ? CHAR_OFFSET_BITS'($urandom) : next_offset;
      it.width  = w;
      it.at_end = fin;
      it.typed  = 1'b0;
      it.want   = NO_TOKEN;
      src_q.insert(src_q.size(), it);
      if (!fin) next_offset = next_offset + CHAR_OFFSET_BITS'(w);
   endtask

   task automatic add_char(input char_type c);
      int r;
      logic [CHAR_WIDTH_BITS-1:0] w;
      r = $urandom_range(0, 99);
      if (r < 70) w = 3'd1;
      else if (r < 97) w = CHAR_WIDTH_BITS'($urandom_range(2, 4));
      else w = CHAR_WIDTH_BITS'($urandom_range(0, 7));
      add_w(c, w, 1'b0);
   endtask

   task automatic add_end();
      add_w(char_type'($urandom_range(0, 255)), CHAR_WIDTH_BITS'($urandom_range(0, 7)), 1'b1);
   endtask

   function automatic char_type rand_letter();
      if ($urandom_range(0, 1))
         return char_type'(CH_UC_A + $urandom_range(0, CH_UC_Z - CH_UC_A));
      return char_type'(CH_LC_A + $urandom_range(0, CH_LC_Z - CH_LC_A));
   endfunction

   function automatic char_type rand_digit(input int top);
      return char_type'(CH_ZERO + $urandom_range(0, top));
   endfunction

   task automatic add_ident();
      int n;
      n = $urandom_range(0, 6);
      add_char(($urandom_range(0, 7) == 0) ? CH_UNDER : rand_letter());
      repeat (n) begin
         case ($urandom_range(0, 5))
            0:       add_char(rand_digit(CH_NINE - CH_ZERO));
            1:       add_char(CH_UNDER);
            default: add_char(rand_letter());
         endcase
      end
   endtask

   task automatic add_keyword();
      add_char($urandom_range(0, 1) ? CH_UC_X : CH_UC_Y);
   endtask

   task automatic add_blanks();
      repeat ($urandom_range(1, 3)) add_char($urandom_range(0, 2) ? CH_SPACE : CH_TAB);
   endtask

   task automatic add_literal();
      int n;
      n = $urandom_range(0, 5);
      case ($urandom_range(0, 2))
         0: begin
            add_char(char_type'(CH_ONE + $urandom_range(0, CH_NINE - CH_ONE)));
            repeat (n) add_char(rand_digit(CH_NINE - CH_ZERO));
         end
         1: begin
            add_char(CH_DOLLAR);
            repeat (n + 1) begin
               case ($urandom_range(0, 2))
                  0: add_char(rand_digit(CH_NINE - CH_ZERO));
                  1: add_char(char_type'(CH_UC_A + $urandom_range(0, CH_UC_F - CH_UC_A)));
                  default: add_char(char_type'(CH_LC_A + $urandom_range(0, CH_LC_F - CH_LC_A)));
               endcase
            end
         end
         default: begin
            add_char(CH_PCENT);
            repeat (n + 1) add_char(rand_digit(1));
         end
      endcase
   endtask

   task automatic add_operand();
      case ($urandom_range(0, 5))
         0: begin add_char(CH_HASH); add_literal(); end
         1: add_literal();
         2: begin
            add_char(CH_LPAREN); add_ident(); add_char(CH_RPAREN);
            add_char(CH_COMMA); add_keyword();
         end
         3: begin add_ident(); add_char(CH_PLUS); add_literal(); end
         4: begin add_literal(); add_char(CH_COMMA); add_keyword(); end
         default: begin
            add_char(CH_MINUS); add_ident(); add_char(CH_STAR);
            add_literal(); add_char(CH_DOT);
         end
      endcase
   endtask

   task automatic add_comment();
      char_type c;
      add_char(CH_SEMI);
      repeat ($urandom_range(0, 12)) begin
         c = char_type'($urandom_range(0, 255));
         add_char((c == CH_CR || c == CH_LF) ? CH_SPACE : c);
      end
   endtask

   // One well-formed source line: [label:] mnemonic [operand] [; comment] EOL
   task automatic add_line();
      int r;
      if ($urandom_range(0, 3) == 0) begin
         add_ident();
         add_char(CH_COLON);
      end
      add_blanks();
      add_ident();
      if ($urandom_range(0, 4) != 0) begin
         add_blanks();
         add_operand();
      end
      if ($urandom_range(0, 2) == 0) begin
         if ($urandom_range(0, 1)) add_blanks();
         add_comment();
      end
      r = $urandom_range(0, 9);
      if (r < 6) add_char(CH_LF);
      else if (r < 9) begin add_char(CH_CR); add_char(CH_LF); end
      else add_char(CH_CR);   // lone CR leads whatever comes next
   endtask

   // Raw bytes of any value: stray CRs, leading zeros, high codes and so on.
   task automatic add_noise();
      repeat ($urandom_range(1, 6)) add_char(char_type'($urandom_range(0, 255)));
   endtask

   // ------------------------------------------------------------------
   // Run statistics
   // ------------------------------------------------------------------
   int  mismatches      = 0;
   int  chars_taken     = 0;
   int  tokens_checked  = 0;
   int  two_token_runs  = 0;
   int  longest_token   = 0;
   bit  kind_seen [16];

   // ------------------------------------------------------------------
   // Stimulus build, sender and end of run
   // ------------------------------------------------------------------
   initial begin
      int            idx;
      int            burst;
      int            gap;
      int            kinds;
      bit            drain;
      bit            offering;
      char_item_type it;

      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.char_code   <= '0;
      req_if.char_offset <= '0;
      req_if.char_width  <= '0;
      req_if.at_end      <= 1'b0;
      offering           = 1'b0;
      lexer_reset();

      foreach (DIRECTED_ROWS[i]) src_q.insert(src_q.size(), DIRECTED_ROWS[i]);

      next_offset = $urandom;

      // Random source: mostly well-formed lines, some noise and end marks
      while (src_q.size() < NUM_DIRECTED + RANDOM_ITEMS) begin
         case ($urandom_range(0, 19)) inside
            [0:14]:  add_line();
            [15:17]: add_noise();
            default: add_end();
         endcase
      end
      add_end();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      idx = 0;
      while (idx < src_q.size()) begin
         // mostly short bursts, now and then a long stretch with no idling
         burst = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
         while (burst > 0 && idx < src_q.size()) begin
            it = src_q[idx];
            req_if.valid       <= 1'b1;
            req_if.char_code   <= it.code;
            req_if.char_offset <= it.offset;
            req_if.char_width  <= it.width;
            req_if.at_end      <= it.at_end;
            offering           = 1'b1;
            @(posedge clock);
            while (!req_if.ready) @(posedge clock);
            // transaction taken at this edge: predict its tokens
            lex_char(it);
            if (it.typed) token_q.insert(token_q.size(), it.want);
            else foreach (run_tokens[i]) token_q.insert(token_q.size(), run_tokens[i]);
            if (run_tokens.size() == 2) two_token_runs++;
            chars_taken++;
            idx++;
            burst--;
            if (idx == NUM_DIRECTED) burst = 0;
         end
         // after the directed table, and now and then later, let the block run dry
         drain = (idx == NUM_DIRECTED) || ($urandom_range(0, 39) == 0);
         gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if ((drain || gap > 0) && offering) begin
            req_if.valid <= 1'b0;
            offering     = 1'b0;
         end
         if (drain) while (token_q.size() != 0) @(posedge clock);
         repeat (gap) @(posedge clock);
      end
      if (offering) req_if.valid <= 1'b0;

      while (token_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      kinds = 0;
      foreach (kind_seen[k]) kinds += kind_seen[k];
      $display("Run: %0d characters in, %0d tokens checked, %0d characters closing two tokens.",
               chars_taken, tokens_checked, two_token_runs);
      $display("Run: %0d distinct token kinds, longest token %0d bytes, %0d mismatches.",
               kinds, longest_token, mismatches);
      if (mismatches == 0)
         $display("** assembly_source_tokenizer_top: PASSED **");
      else
         $display("** assembly_source_tokenizer_top: FAILED **");
      $finish;
   end

   // ------------------------------------------------------------------
   // Receiver: stalls on its own pattern, with a long hold-off every so often
   // so the token queue fills and req_if.ready has to drop.
   // ------------------------------------------------------------------
   initial begin
      rx_mode_type mode;
      int          seg;
      int          len;
      logic        rdy;
      seg = 0;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         seg++;
         if (seg % 20 == 4) begin
            mode = RX_HOLD;
            len  = HOLD_CYCLES;
         end else begin
            mode = rx_mode_type'($urandom_range(RX_ALWAYS, RX_SPARSE));
            len  = $urandom_range(10, 150);
         end
         repeat (len) begin
            case (mode)
               RX_ALWAYS: rdy = 1'b1;
               RX_COIN:   rdy = 1'($urandom_range(0, 1));
               RX_SPARSE: rdy = ($urandom_range(0, 4) == 0);
               default:   rdy = 1'b0;
            endcase
            rsp_if.ready <= rdy;
            @(posedge clock);
         end
      end
   end

   // ------------------------------------------------------------------
   // Token checker: each accepted token against the oldest expectation
   // ------------------------------------------------------------------
   function automatic bit field_ok(input string name, input logic [31:0] want,
                                   input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: token %0d %s mismatch, expected %0h, actual %0h",
                  $time, tokens_checked, name, want, got);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      tok_rec_type want;
      tok_rec_type got;
      bit          ok;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.kind         = rsp_if.token_kind;
         got.start        = rsp_if.token_start;
         got.length       = rsp_if.token_length;
         got.space_before = rsp_if.space_before;
         got.line_start   = rsp_if.line_start;
         got.trivia       = rsp_if.trivia;
         got.last_of_run  = rsp_if.last_of_run;
         if (token_q.size() == 0) begin
            $display("%0t ns: unexpected token, expected none, actual kind %0d start %0h len %0d",
                     $time, got.kind, got.start, got.length);
            mismatches++;
         end else begin
            want = token_q.pop_front();
            // bitwise and, so every bad field gets reported
            ok = field_ok("kind", 32'(want.kind), 32'(got.kind)) &
                 field_ok("start", 32'(want.start), 32'(got.start)) &
                 field_ok("length", 32'(want.length), 32'(got.length)) &
                 field_ok("space_before", 32'(want.space_before), 32'(got.space_before)) &
                 field_ok("line_start", 32'(want.line_start), 32'(got.line_start)) &
                 field_ok("trivia", 32'(want.trivia), 32'(got.trivia)) &
                 field_ok("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
            if (!ok) mismatches++;
            kind_seen[want.kind] = 1'b1;
            if (int'(want.length) > longest_token) longest_token = int'(want.length);
            tokens_checked++;
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: too long with no transaction on either side means a hang
   // ------------------------------------------------------------------
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
         else quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles, %0d tokens outstanding",
                     $time, quiet, token_q.size());
            $display("** assembly_source_tokenizer_top: FAILED **");
            $finish;
         end
      end
   end

endmodule
